/* hw/rtl/tlv_record_splitter_assert.svh */
// Assertion macros for the record splitter RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef TLV_RECORD_SPLITTER_ASSERT_SVH
`define TLV_RECORD_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, switched off while reset is held.
`define TLVS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define TLVS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TLVS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLVS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/tlvs_pkg.sv */
`default_nettype none

package tlvs_pkg;

    localparam logic [7:0] TAG_EXT_MASK  = 8'h1F;
    localparam logic [7:0] LEN_SHORT_MAX = 8'h7F;
    localparam logic [15:0] MIN_RECORD   = 16'd3;

    typedef enum logic [2:0] {
        PH_TAG1    = 3'd0,
        PH_TAG2    = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LEN2    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER_BYTE = 2'd0,
        KIND_HEADER_DONE = 2'd1,
        KIND_PAYLOAD     = 2'd2,
        KIND_ERROR       = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SHORT     = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_HDR_CUT   = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] bytes_left;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] tag;
        logic [7:0]  length;
        logic [2:0]  header_size;
        logic [15:0] record_offset;
        logic [7:0]  payload_byte;
        logic        last_of_record;
        t_err        error_code;
    } t_out_word;

endpackage

`default_nettype wire

/* hw/rtl/tlv_record_splitter.sv */
// channel | direction | handshake                | word
// --------+-----------+--------------------------+--------------------------
// in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_word)
// out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_word)
//
// One word per cycle sustained while the output is not stalled; a taken input word
// goes into the input register, then through the parse logic into the result register.
// The parser state updates in the cycle a word moves into the result register.
// Reset (i_rst_n low, synchronous) empties both registers and idles the parser.
// A stalled output holds the result register; the input register still takes
// a word while it is empty.

`default_nettype none

module tlv_record_splitter
    import tlvs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_data
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      advance;
    t_out_word result;

    // move a word into the result register when it is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    tlvs_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/tlvs_parse.sv */
`default_nettype none

module tlvs_parse
    import tlvs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    output t_out_word      o_result
);

`include "tlv_record_splitter_assert.svh"

    t_phase      r_phase,  n_phase;
    logic [15:0] r_tag,    n_tag;
    logic [7:0]  r_plen,   n_plen;
    logic [7:0]  r_prem,   n_prem;
    logic [2:0]  r_hdr,    n_hdr;
    logic [15:0] r_pos;
    logic [15:0] r_rstart, n_rstart;

    logic [7:0]  b;
    logic [15:0] bl;
    logic        at_end;
    logic        overflow;
    t_kind       kind;
    t_err        err;
    logic        last;
    logic [7:0]  pbyte;

    assign b        = i_word.data_byte;
    assign bl       = i_word.bytes_left;
    assign at_end   = (bl <= 16'd1);
    assign overflow = ({9'd0, b} + 17'd1) > {1'b0, bl};

    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_plen   = r_plen;
        n_prem   = r_prem;
        n_hdr    = r_hdr;
        n_rstart = r_rstart;
        kind     = KIND_HEADER_BYTE;
        err      = ERR_NONE;
        last     = 1'b0;
        pbyte    = 8'd0;

        unique case (r_phase) inside
            PH_TAG1: begin
                n_rstart = r_pos;
                n_tag    = 16'd0;
                n_plen   = 8'd0;
                n_prem   = 8'd0;
                n_hdr    = 3'd0;
                if (bl < MIN_RECORD) begin
                    kind    = KIND_ERROR;
                    err     = ERR_SHORT;
                    n_phase = PH_DROP;
                end else begin
                    n_tag   = {8'd0, b};
                    n_hdr   = 3'd1;
                    n_phase = ((b & TAG_EXT_MASK) != 8'd0) ? PH_TAG2 : PH_LEN1;
                end
            end
            PH_TAG2: begin
                n_tag = {r_tag[7:0], b};
                n_hdr = 3'd2;
                if (at_end) begin
                    kind    = KIND_ERROR;
                    err     = ERR_HDR_CUT;
                    n_phase = PH_DROP;
                end else begin
                    n_phase = PH_LEN1;
                end
            end
            PH_LEN1, PH_LEN2: begin
                n_hdr = 3'(r_hdr + 3'd1);
                if (r_phase == PH_LEN1 && b > LEN_SHORT_MAX) begin
                    // long form: real length follows
                    if (at_end) begin
                        kind    = KIND_ERROR;
                        err     = ERR_HDR_CUT;
                        n_phase = PH_DROP;
                    end else begin
                        n_phase = PH_LEN2;
                    end
                end else begin
                    n_plen = b;
                    if (overflow) begin
                        kind    = KIND_ERROR;
                        err     = ERR_OVERFLOW;
                        n_phase = PH_DROP;
                    end else if (b == 8'd0) begin
                        kind    = KIND_HEADER_DONE;
                        last    = 1'b1;
                        n_phase = PH_TAG1;
                    end else begin
                        kind    = KIND_HEADER_DONE;
                        n_prem  = b;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                kind  = KIND_PAYLOAD;
                pbyte = b;
                if (r_prem != 8'd0) begin
                    n_prem = r_prem - 8'd1;
                end
                if (n_prem == 8'd0) begin
                    last    = 1'b1;
                    n_phase = PH_TAG1;
                end
            end
            PH_DROP: begin
                kind = KIND_HEADER_BYTE;
            end
            default: begin
                n_phase = PH_DROP;
            end
        endcase
    end

    always_comb begin
        o_result.kind           = kind;
        o_result.tag            = n_tag;
        o_result.length         = n_plen;
        o_result.header_size    = n_hdr;
        o_result.record_offset  = n_rstart;
        o_result.payload_byte   = pbyte;
        o_result.last_of_record = last;
        o_result.error_code     = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && at_end)) begin
            // region end returns the parser to its idle state
            r_phase  <= PH_TAG1;
            r_tag    <= 16'd0;
            r_plen   <= 8'd0;
            r_prem   <= 8'd0;
            r_hdr    <= 3'd0;
            r_pos    <= 16'd0;
            r_rstart <= 16'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_plen   <= n_plen;
            r_prem   <= n_prem;
            r_hdr    <= n_hdr;
            r_pos    <= r_pos + 16'd1;
            r_rstart <= n_rstart;
        end
    end

    `TLVS_ASSERT(a_end_resets, i_clk, i_rst_n, (i_step && at_end) |=> (r_phase == PH_TAG1 && r_pos == 16'd0), "region end did not reset parser")
    `TLVS_ASSERT(a_pos_advance, i_clk, i_rst_n, (i_step && !at_end) |=> (r_pos == 16'($past(r_pos) + 16'd1)), "region position did not advance")
    `TLVS_ASSERT_ALWAYS(a_payload_pending, i_clk, (r_phase == PH_PAYLOAD) |-> (r_prem != 8'd0), "payload phase with nothing remaining")
    `TLVS_ASSERT(a_err_kind, i_clk, i_rst_n, i_step |-> ((o_result.error_code != ERR_NONE) == (o_result.kind == KIND_ERROR)), "error code and kind disagree")

endmodule

`default_nettype wire

/* test/tb_top.sv */
`default_nettype none

module tb_top;
    import tlvs_pkg::*;

    typedef struct {
        t_in_word w;
        bit       drain;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_data = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_data;

    t_pending    pend_q[$];
    t_out_word   parse_q[$];
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail = 0;
    int unsigned kind_seen[4];
    int unsigned err_seen[4];

    // parser image
    t_phase      ph;
    logic [15:0] tagv;
    logic [7:0]  plen;
    logic [7:0]  prem;
    logic [2:0]  hbytes;
    logic [15:0] pos;
    logic [15:0] rstart;

    tlv_record_splitter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        ph     = PH_TAG1;
        tagv   = '0;
        plen   = '0;
        prem   = '0;
        hbytes = '0;
        pos    = '0;
        rstart = '0;
    endfunction

    function automatic void close_header(input logic [7:0] len, input logic [15:0] bl,
                                         inout t_out_word r);
        plen = len;
        if (({9'd0, len} + 17'd1) > {1'b0, bl}) begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_OVERFLOW;
            ph           = PH_DROP;
        end else begin
            r.kind = KIND_HEADER_DONE;
            if (len == 8'd0) begin
                r.last_of_record = 1'b1;
                ph               = PH_TAG1;
            end else begin
                prem = len;
                ph   = PH_PAYLOAD;
            end
        end
    endfunction

    function automatic t_out_word parse_byte(input t_in_word w);
        t_out_word   r;
        logic [7:0]  b;
        logic [15:0] bl;
        logic        at_end;
        b      = w.data_byte;
        bl     = w.bytes_left;
        at_end = (bl <= 16'd1);
        r            = '0;
        r.kind       = KIND_HEADER_BYTE;
        r.error_code = ERR_NONE;
        case (ph)
            PH_TAG1: begin
                rstart = pos;
                tagv   = '0;
                plen   = '0;
                prem   = '0;
                hbytes = '0;
                if (bl < MIN_RECORD) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_SHORT;
                    ph           = PH_DROP;
                end else begin
                    tagv   = {8'h00, b};
                    hbytes = 3'd1;
                    if ((b & TAG_EXT_MASK) != 8'h00) begin
                        ph = PH_TAG2;
                    end else begin
                        ph = PH_LEN1;
                    end
                end
            end
            PH_TAG2: begin
                tagv   = {tagv[7:0], b};
                hbytes = 3'd2;
                if (at_end) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_HDR_CUT;
                    ph           = PH_DROP;
                end else begin
                    ph = PH_LEN1;
                end
            end
            PH_LEN1: begin
                hbytes = hbytes + 3'd1;
                if (b > LEN_SHORT_MAX) begin
                    if (at_end) begin
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_HDR_CUT;
                        ph           = PH_DROP;
                    end else begin
                        ph = PH_LEN2;
                    end
                end else begin
                    close_header(b, bl, r);
                end
            end
            PH_LEN2: begin
                hbytes = hbytes + 3'd1;
                close_header(b, bl, r);
            end
            PH_PAYLOAD: begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                if (prem != 8'd0) prem = prem - 8'd1;
                if (prem == 8'd0) begin
                    r.last_of_record = 1'b1;
                    ph               = PH_TAG1;
                end
            end
            default: ;
        endcase
        r.tag           = tagv;
        r.length        = plen;
        r.header_size   = hbytes;
        r.record_offset = rstart;
        // a region end wipes the whole parser, cut-short payload included
        if (at_end) begin
            clear_parser();
        end else begin
            pos = pos + 16'd1;
        end
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic [15:0] bl,
                                      input bit drain = 1'b0);
        t_pending p;
        p.w.data_byte  = b;
        p.w.bytes_left = bl;
        p.drain        = drain;
        pend_q.push_back(p);
    endfunction

    function automatic void push_region(input logic [7:0] body[$]);
        for (int i = 0; i < body.size(); i++) begin
            push_byte(body[i], 16'(body.size() - i));
        end
    endfunction

    // Mostly well-formed regions, with truncation, trailing stubs and corruption mixed in.
    function automatic void add_region();
        logic [7:0] body[$];
        logic [7:0] t1;
        int         nrec;
        int         len;
        int         pick;
        nrec = $urandom_range(1, 4);
        for (int k = 0; k < nrec; k++) begin
            t1 = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) t1 = t1 & 8'hE0;
            body.push_back(t1);
            if ((t1 & TAG_EXT_MASK) != 8'h00) body.push_back(8'($urandom_range(0, 255)));
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                len = $urandom_range(100, 255);
            end else if (pick < 4) begin
                len = 0;
            end else begin
                len = $urandom_range(1, 12);
            end
            if (len > 127 || $urandom_range(0, 3) == 0) begin
                body.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            body.push_back(8'(len));
            for (int j = 0; j < len; j++) body.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            len = $urandom_range(1, (body.size() > 3) ? 3 : body.size() - 1);
            repeat (len) void'(body.pop_back());
        end else if (pick == 1) begin
            repeat ($urandom_range(1, 2)) body.push_back(8'($urandom_range(0, 255)));
        end else if (pick == 2) begin
            body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        end
        push_region(body);
    endfunction

    function automatic bit calm(input int unsigned n);
        return n >= 250 && n < 350;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : drv
        logic        taken;
        int unsigned sent_now;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            taken    = in_valid && in_ready;
            sent_now = n_sent + (taken ? 1 : 0);
            if (taken) begin
                parse_q.push_back(parse_byte(in_data));
                n_sent <= sent_now;
            end
            if (!in_valid || taken) begin
                // hold a draining word back until every result is in
                if (pend_q.size() != 0 && !(pend_q[0].drain && sent_now != n_checked)
                        && (calm(sent_now) || $urandom_range(0, 99) >= 9)) begin
                    in_data  <= pend_q[0].w;
                    in_valid <= 1'b1;
                    pend_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : mon
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got = out_data;
                if (parse_q.size() == 0) begin
                    $error("result word with nothing expected: 0x%0h", got);
                    n_fail++;
                end else begin
                    want = parse_q.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("tag", want.tag, got.tag);
                    check_field("length", want.length, got.length);
                    check_field("header_size", want.header_size, got.header_size);
                    check_field("record_offset", want.record_offset, got.record_offset);
                    check_field("payload_byte", want.payload_byte, got.payload_byte);
                    check_field("last_of_record", want.last_of_record, got.last_of_record);
                    check_field("error_code", want.error_code, got.error_code);
                    kind_seen[want.kind]++;
                    err_seen[want.error_code]++;
                    n_checked <= n_checked + 1;
                end
            end
            out_ready <= calm(n_checked) || ($urandom_range(0, 99) >= 9);
        end
    end

    initial begin
        #800000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stim
        int mark;
        clear_parser();
        // one-byte region and two-byte region: too short
        push_byte(8'hFF, 16'd1);
        push_byte(8'h00, 16'd2);
        push_byte(8'hFF, 16'd1);
        // zero bytes left counts as a region end
        push_byte(8'hA5, 16'd0);
        // one-byte tag, short length, single payload byte
        push_byte(8'h00, 16'd3);
        push_byte(8'h01, 16'd2);
        push_byte(8'hFF, 16'd1);
        // two-byte tag, long form with zero length: empty record
        push_byte(8'hFF, 16'd4);
        push_byte(8'hFF, 16'd3);
        push_byte(8'h80, 16'd2);
        push_byte(8'h00, 16'd1);
        // payload longer than the region
        push_byte(8'h40, 16'd3);
        push_byte(8'h05, 16'd2);
        push_byte(8'h33, 16'd1);
        // region ends on the second tag byte
        push_byte(8'h1F, 16'd5);
        push_byte(8'hAB, 16'd1);
        // region ends on a long-form length byte
        push_byte(8'h01, 16'd3);
        push_byte(8'h7E, 16'd2);
        push_byte(8'hFF, 16'd1);
        // long-form length, three payload bytes
        push_byte(8'h00, 16'd6);
        push_byte(8'h80, 16'd5);
        push_byte(8'h03, 16'd4);
        push_byte(8'h55, 16'd3);
        push_byte(8'hAA, 16'd2);
        push_byte(8'h0F, 16'd1);

        mark = pend_q.size();
        add_region();
        pend_q[mark].drain = 1'b1;
        while (pend_q.size() < 575) begin
            mark = pend_q.size();
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    push_byte(8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)));
                end
            end else begin
                add_region();
            end
            if ($urandom_range(0, 11) == 0) pend_q[mark].drain = 1'b1;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pend_q.size() != 0 || in_valid || n_sent != n_checked);
        repeat (10) @(posedge i_clk);

        if (parse_q.size() != 0) begin
            $error("%0d expected result words never arrived", parse_q.size());
            n_fail++;
        end
        $display("%0d words parsed: %0d header bytes, %0d headers done, %0d payload, %0d errors",
                 n_checked, kind_seen[KIND_HEADER_BYTE], kind_seen[KIND_HEADER_DONE],
                 kind_seen[KIND_PAYLOAD], kind_seen[KIND_ERROR]);
        $display("error mix: %0d short region, %0d overflow, %0d header cut",
                 err_seen[ERR_SHORT], err_seen[ERR_OVERFLOW], err_seen[ERR_HDR_CUT]);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
